>>> rtl/pulse_beat_rate_detector_macros.svh
// Assertion macros shared by the pulse beat rate detector RTL.
// Used by pbrd_ctrl and pulse_beat_rate_detector; expects clock and reset in scope.
`ifndef PULSE_BEAT_RATE_DETECTOR_MACROS_SVH
`define PULSE_BEAT_RATE_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define PBRD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define PBRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PBRD_ASSERT_IMPL(lbl, ante, cons, msg)
`define PBRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/pbrd_pkg.sv
// Package for the pulse beat rate detector: sizes, reset values, register
// indexes, controller states and the controller/datapath interface structs.
`default_nettype none

package pbrd_pkg;

   localparam int RING_DEPTH  = 5;
   localparam int SAMPLE_BITS = 12;

   localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int IVL_W   = 16;
   localparam int STAMP_W = 32;
   localparam int SUM_W   = IVL_W + CNT_W;
   localparam int DIV_W   = SUM_W;
   localparam int RATE_W  = 8;
   localparam int SPAN_W  = 12;
   localparam int CMP_W   = ((SAMPLE_BITS > SPAN_W) ? SAMPLE_BITS : SPAN_W) + 1;
   localparam int SPAN7_W = SAMPLE_BITS + 3;

   // x / 10 == (x * 838861) >> 23 for every x below 2^22.
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 23;
   localparam logic [RECIP_W-1:0] RECIP10 = 20'd838861;
   localparam int PROD_W = SPAN7_W + RECIP_W;

   localparam logic [DIV_W-1:0] RATE_NUM = DIV_W'(60000);

   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam logic [SAMPLE_BITS-1:0] LEVEL_RST  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam logic [CSR_W-1:0]  WINDOW_RST  = 16'd500;
   localparam logic [CSR_W-1:0]  MIN_IVL_RST = 16'd300;
   localparam logic [CSR_W-1:0]  MAX_IVL_RST = 16'd2000;
   localparam logic [CSR_W-1:0]  TIMEOUT_RST = 16'd4000;
   localparam logic [SPAN_W-1:0] MIN_SPAN_RST = 12'd50;
   localparam logic [SPAN_W-1:0] HYST_RST     = 12'd50;
   localparam logic [RATE_W-1:0] FLOOR_RST    = 8'd30;
   localparam logic [RATE_W-1:0] CEIL_RST     = 8'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_MS       = 3'd0,
      CSR_MIN_INTERVAL_MS = 3'd1,
      CSR_MAX_INTERVAL_MS = 3'd2,
      CSR_TIMEOUT_MS      = 3'd3,
      CSR_MIN_SPAN        = 3'd4,
      CSR_HYSTERESIS      = 3'd5,
      CSR_RATE_FLOOR      = 3'd6,
      CSR_RATE_CEILING    = 3'd7
   } pbrd_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WIN,
      S_SPAN,
      S_LEVEL,
      S_BEAT,
      S_SUM,
      S_DIV1_GO,
      S_DIV1_WAIT,
      S_DIV2_GO,
      S_DIV2_WAIT,
      S_CLAMP,
      S_TIMEOUT,
      S_DONE
   } pbrd_state_type;

   typedef struct packed {
      logic ld_item;
      logic do_win;
      logic do_span;
      logic do_level;
      logic do_beat;
      logic sum_step;
      logic div_start;
      logic div_second;
      logic do_clamp;
      logic do_timeout;
      logic ld_out;
   } pbrd_cmd_type;

   typedef struct packed {
      logic accept_ivl;
      logic sum_last;
      logic div_done;
      logic div_busy;
      logic avg_zero;
      logic out_busy;
   } pbrd_sts_type;

endpackage

`default_nettype wire

>>> rtl/pbrd_div.sv
// Restoring divider, one quotient bit per cycle, shared for both divisions.
// Depends on pbrd_pkg for the operand width.
`default_nettype none

module pbrd_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [pbrd_pkg::DIV_W-1:0] dividend,
   input  wire logic [pbrd_pkg::DIV_W-1:0] divisor,
   output logic                          busy,
   output logic                          done,
   output logic [pbrd_pkg::DIV_W-1:0]    quotient
);
   import pbrd_pkg::*;

   localparam int CW = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;

   always_comb begin
      logic [DIV_W:0] shifted;
      logic [DIV_W:0] diff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/pbrd_dp.sv
// Datapath of the pulse beat rate detector: settings, window tracking,
// threshold, interval ring, rate arithmetic and the result register.
// Depends on pbrd_pkg and pbrd_div.
`default_nettype none

module pbrd_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [pbrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pbrd_pkg::CSR_W-1:0]       csr_wdata,
   input  wire logic [pbrd_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic [pbrd_pkg::STAMP_W-1:0]     req_now_ms,
   input  wire pbrd_pkg::pbrd_cmd_type           cmd,
   output pbrd_pkg::pbrd_sts_type                sts,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_valid,
   output logic [pbrd_pkg::RATE_W-1:0]           rsp_rate_bpm,
   output logic                                  rsp_beat_seen,
   output logic                                  rsp_in_beat,
   output logic [pbrd_pkg::SAMPLE_BITS-1:0]      rsp_level
);
   import pbrd_pkg::*;

   // Settings.
   logic [CSR_W-1:0]  window_ff, window_in;
   logic [CSR_W-1:0]  min_ivl_ff, min_ivl_in;
   logic [CSR_W-1:0]  max_ivl_ff, max_ivl_in;
   logic [CSR_W-1:0]  timeout_ff, timeout_in;
   logic [SPAN_W-1:0] min_span_ff, min_span_in;
   logic [SPAN_W-1:0] hyst_ff, hyst_in;
   logic [RATE_W-1:0] floor_ff, floor_in;
   logic [RATE_W-1:0] ceil_ff, ceil_in;

   // Detector state.
   logic [SAMPLE_BITS-1:0] win_low_ff, win_low_in;
   logic [SAMPLE_BITS-1:0] win_high_ff, win_high_in;
   logic [SAMPLE_BITS-1:0] level_ff, level_in;
   logic [STAMP_W-1:0]     win_start_ff, win_start_in;
   logic [STAMP_W-1:0]     last_ff, last_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   armed_ff, armed_in;
   logic [RATE_W-1:0]      rate_ff, rate_in;
   logic                   beat_ff, beat_in;
   logic                   span_hit_ff, span_hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers and the ring.
   logic [IVL_W-1:0]       ring_ff [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [STAMP_W-1:0]     now_ff;
   logic [SPAN7_W-1:0]     span7_ff, span7_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [RATE_W-1:0]      rsp_rate_ff;
   logic                   rsp_beat_ff;
   logic                   rsp_armed_ff;
   logic [SAMPLE_BITS-1:0] rsp_level_ff;

   logic [STAMP_W-1:0] iv;
   logic               beat_now;
   logic               iv_ok;
   logic [DIV_W-1:0]   div_dividend;
   logic [DIV_W-1:0]   div_divisor;
   logic               div_busy;
   logic               div_done;
   logic [DIV_W-1:0]   quotient;

   assign iv       = now_ff - last_ff;
   assign beat_now = !armed_ff && (sample_ff > level_ff);
   assign iv_ok    = (last_ff != '0) && (iv >= STAMP_W'(min_ivl_ff))
                     && (iv <= STAMP_W'(max_ivl_ff));

   // The first division is sum / fill, the second 60000 / mean.
   assign div_dividend = cmd.div_second ? RATE_NUM : sum_ff;
   assign div_divisor  = cmd.div_second ? quotient : DIV_W'(fill_ff);

   pbrd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      sts.accept_ivl = beat_now && iv_ok;
      sts.sum_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == fill_ff;
      sts.div_done   = div_done;
      sts.div_busy   = div_busy;
      sts.avg_zero   = quotient == '0;
      sts.out_busy   = rsp_valid_ff && rsp_stall;
   end

   // Settings writes.
   always_comb begin
      window_in   = window_ff;
      min_ivl_in  = min_ivl_ff;
      max_ivl_in  = max_ivl_ff;
      timeout_in  = timeout_ff;
      min_span_in = min_span_ff;
      hyst_in     = hyst_ff;
      floor_in    = floor_ff;
      ceil_in     = ceil_ff;
      if (csr_we) begin
         case (pbrd_csr_type'(csr_index))
            CSR_WINDOW_MS:       window_in   = csr_wdata;
            CSR_MIN_INTERVAL_MS: min_ivl_in  = csr_wdata;
            CSR_MAX_INTERVAL_MS: max_ivl_in  = csr_wdata;
            CSR_TIMEOUT_MS:      timeout_in  = csr_wdata;
            CSR_MIN_SPAN:        min_span_in = csr_wdata[SPAN_W-1:0];
            CSR_HYSTERESIS:      hyst_in     = csr_wdata[SPAN_W-1:0];
            CSR_RATE_FLOOR:      floor_in    = csr_wdata[RATE_W-1:0];
            CSR_RATE_CEILING:    ceil_in     = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Per-step datapath operations.
   always_comb begin
      logic [STAMP_W-1:0]     elapsed;
      logic                   restart;
      logic [SAMPLE_BITS-1:0] lo_base;
      logic [SAMPLE_BITS-1:0] hi_base;
      logic [SAMPLE_BITS-1:0] span;
      logic [PROD_W-1:0]      prod;
      logic                   armed_set;
      logic                   rearm;
      logic [DIV_W-1:0]       r_floor;
      logic [DIV_W-1:0]       r_ceil;

      win_low_in   = win_low_ff;
      win_high_in  = win_high_ff;
      level_in     = level_ff;
      win_start_in = win_start_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      armed_in     = armed_ff;
      rate_in      = rate_ff;
      beat_in      = beat_ff;
      span_hit_in  = span_hit_ff;
      span7_in     = span7_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;

      elapsed   = now_ff - win_start_ff;
      restart   = elapsed > STAMP_W'(window_ff);
      lo_base   = restart ? SAMPLE_MAX : win_low_ff;
      hi_base   = restart ? '0 : win_high_ff;
      span      = win_high_ff - win_low_ff;
      prod      = PROD_W'(span7_ff) * PROD_W'(RECIP10);
      armed_set = armed_ff || beat_now;
      rearm     = (CMP_W'(sample_ff) + CMP_W'(hyst_ff)) < CMP_W'(level_ff);
      r_floor   = (quotient < DIV_W'(floor_ff)) ? DIV_W'(floor_ff) : quotient;
      r_ceil    = (r_floor > DIV_W'(ceil_ff)) ? DIV_W'(ceil_ff) : r_floor;

      if (cmd.do_win) begin
         win_low_in  = (sample_ff < lo_base) ? sample_ff : lo_base;
         win_high_in = (sample_ff > hi_base) ? sample_ff : hi_base;
         if (restart) begin
            win_start_in = now_ff;
         end
      end

      if (cmd.do_span) begin
         span_hit_in = CMP_W'(win_high_ff) > (CMP_W'(win_low_ff) + CMP_W'(min_span_ff));
         span7_in    = (SPAN7_W'(span) << 3) - SPAN7_W'(span);
      end

      if (cmd.do_level && span_hit_ff) begin
         level_in = win_low_ff + prod[RECIP_SHIFT +: SAMPLE_BITS];
      end

      if (cmd.do_beat) begin
         beat_in  = beat_now;
         armed_in = armed_set && !rearm;
         sum_in   = '0;
         idx_in   = '0;
         if (beat_now) begin
            last_in = now_ff;
            if (iv_ok) begin
               pos_in = (pos_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : pos_ff + IDX_W'(1);
               if (fill_ff != CNT_W'(RING_DEPTH)) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
      end

      if (cmd.sum_step) begin
         sum_in = sum_ff + SUM_W'(ring_ff[idx_ff]);
         idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.do_clamp) begin
         rate_in = r_ceil[RATE_W-1:0];
      end

      if (cmd.do_timeout && (last_ff != '0) && (iv > STAMP_W'(timeout_ff))) begin
         rate_in = '0;
         fill_in = '0;
         pos_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.ld_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RST;
         min_ivl_ff   <= MIN_IVL_RST;
         max_ivl_ff   <= MAX_IVL_RST;
         timeout_ff   <= TIMEOUT_RST;
         min_span_ff  <= MIN_SPAN_RST;
         hyst_ff      <= HYST_RST;
         floor_ff     <= FLOOR_RST;
         ceil_ff      <= CEIL_RST;
         win_low_ff   <= SAMPLE_MAX;
         win_high_ff  <= '0;
         level_ff     <= LEVEL_RST;
         win_start_ff <= '0;
         last_ff      <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         armed_ff     <= 1'b0;
         rate_ff      <= '0;
         beat_ff      <= 1'b0;
         span_hit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         min_ivl_ff   <= min_ivl_in;
         max_ivl_ff   <= max_ivl_in;
         timeout_ff   <= timeout_in;
         min_span_ff  <= min_span_in;
         hyst_ff      <= hyst_in;
         floor_ff     <= floor_in;
         ceil_ff      <= ceil_in;
         win_low_ff   <= win_low_in;
         win_high_ff  <= win_high_in;
         level_ff     <= level_in;
         win_start_ff <= win_start_in;
         last_ff      <= last_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         armed_ff     <= armed_in;
         rate_ff      <= rate_in;
         beat_ff      <= beat_in;
         span_hit_ff  <= span_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; entries of the ring are only read after being written.
   always_ff @(posedge clock) begin
      if (cmd.ld_item) begin
         sample_ff <= req_sample;
         now_ff    <= req_now_ms;
      end
      if (cmd.do_beat && beat_now && iv_ok) begin
         ring_ff[pos_ff] <= iv[IVL_W-1:0];
      end
      span7_ff <= span7_in;
      sum_ff   <= sum_in;
      idx_ff   <= idx_in;
      if (cmd.ld_out) begin
         rsp_rate_ff  <= rate_ff;
         rsp_beat_ff  <= beat_ff;
         rsp_armed_ff <= armed_ff;
         rsp_level_ff <= level_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rate_bpm  = rsp_rate_ff;
   assign rsp_beat_seen = rsp_beat_ff;
   assign rsp_in_beat   = rsp_armed_ff;
   assign rsp_level     = rsp_level_ff;

endmodule

`default_nettype wire

>>> rtl/pbrd_ctrl.sv
// Sequencer of the pulse beat rate detector: steps one sample through the
// datapath. Depends on pbrd_pkg and the assertion macro header.
`default_nettype none
`include "pulse_beat_rate_detector_macros.svh"

module pbrd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pbrd_pkg::pbrd_sts_type sts,
   output pbrd_pkg::pbrd_cmd_type      cmd
);
   import pbrd_pkg::*;

   pbrd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.ld_item = 1'b1;
               state_in    = S_WIN;
            end
         end
         S_WIN: begin
            cmd.do_win = 1'b1;
            state_in   = S_SPAN;
         end
         S_SPAN: begin
            cmd.do_span = 1'b1;
            state_in    = S_LEVEL;
         end
         S_LEVEL: begin
            cmd.do_level = 1'b1;
            state_in     = S_BEAT;
         end
         S_BEAT: begin
            cmd.do_beat = 1'b1;
            state_in    = sts.accept_ivl ? S_SUM : S_TIMEOUT;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = S_DIV1_GO;
            end
         end
         S_DIV1_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (sts.div_done) begin
               state_in = S_DIV2_GO;
            end
         end
         S_DIV2_GO: begin
            // A zero mean leaves a zero quotient, which the clamp bounds by floor and ceiling.
            if (sts.avg_zero) begin
               state_in = S_CLAMP;
            end else begin
               cmd.div_start  = 1'b1;
               cmd.div_second = 1'b1;
               state_in       = S_DIV2_WAIT;
            end
         end
         S_DIV2_WAIT: begin
            if (sts.div_done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.do_clamp = 1'b1;
            state_in     = S_TIMEOUT;
         end
         S_TIMEOUT: begin
            cmd.do_timeout = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.ld_out = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `PBRD_ASSERT_IMPL(a_div_done_in_wait, sts.div_done, (state_ff == S_DIV1_WAIT) || (state_ff == S_DIV2_WAIT), "divider finished outside a wait state")
   `PBRD_ASSERT_IMPL(a_div_start_free, cmd.div_start, !sts.div_busy, "divider restarted while busy")
   `PBRD_ASSERT_NEXT(a_sum_bounded, cmd.do_beat && sts.accept_ivl, state_ff == S_SUM, "accepted interval did not start the ring sum")

endmodule

`default_nettype wire

>>> rtl/pulse_beat_rate_detector.sv
// Top level of the pulse beat rate detector: sequencer plus datapath.
// Depends on pbrd_pkg, pbrd_ctrl, pbrd_dp and the assertion macro header.
`default_nettype none
`include "pulse_beat_rate_detector_macros.svh"

// Adaptive-threshold heart rate detector. Each req beat carries one pulse
// sample and its millisecond time stamp; each one yields exactly one rsp beat
// with the current rate in beats per minute, a flag for a beat that started on
// this sample, the in-beat flag and the current adaptive threshold. The window
// minimum and maximum restart once more than window_ms has elapsed since the
// window began; when their spread exceeds min_span the threshold moves to
// minimum plus seven tenths of the spread. A rising crossing while not in a
// beat is a beat; its interval, if within the configured limits, enters a
// five-entry ring and the rate becomes 60000 divided by the ring mean, clamped
// to rate_floor and then rate_ceiling. Detection re-arms when the sample drops
// more than hysteresis below the threshold, and timeout_ms of silence after the
// last beat zeroes the rate and empties the ring. Samples are processed one at
// a time: a sample with no new interval skips the ring sum and the divisions;
// one that adds an interval sums the N ring entries (N the ring fill, 1 to 5)
// and uses one shared restoring divider that resolves one quotient bit per
// cycle for the mean and then for the rate. The result sits in an output
// register, so the next sample is accepted while a result waits on rsp_stall.
// Settings, written through csr_we, csr_index and csr_wdata, apply from the next
// sample; the user must write them only while the block is idle (not enforced).
module pulse_beat_rate_detector (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [pbrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pbrd_pkg::CSR_W-1:0]       csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [pbrd_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic [pbrd_pkg::STAMP_W-1:0]     req_now_ms,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [pbrd_pkg::RATE_W-1:0]           rsp_rate_bpm,
   output logic                                  rsp_beat_seen,
   output logic                                  rsp_in_beat,
   output logic [pbrd_pkg::SAMPLE_BITS-1:0]      rsp_level
);
   import pbrd_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   pbrd_cmd_type cmd;
   pbrd_sts_type sts;

   pbrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbrd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_sample    (req_sample),
      .req_now_ms    (req_now_ms),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_rate_bpm  (rsp_rate_bpm),
      .rsp_beat_seen (rsp_beat_seen),
      .rsp_in_beat   (rsp_in_beat),
      .rsp_level     (rsp_level)
   );

   // A sample that starts a beat can never re-arm on the same sample.
   `PBRD_ASSERT_IMPL(a_beat_is_armed, rsp_valid && rsp_beat_seen, rsp_in_beat, "beat reported without in-beat flag")
   // The block works on one sample at a time.
   `PBRD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second sample accepted while busy")

endmodule

`default_nettype wire

>>> dv/tb_pulse_beat_rate_detector.sv
// Self-checking testbench for pulse_beat_rate_detector: drives pulse samples with time
// stamps and compares every reading against an in-bench model of the heart rate tracker.
// Depends on pbrd_pkg and the RTL of pulse_beat_rate_detector only.
`timescale 1ns / 1ps

module tb_pulse_beat_rate_detector;
   import pbrd_pkg::*;

   typedef logic [SAMPLE_BITS-1:0] pulse_t;
   typedef logic [STAMP_W-1:0]     stamp_t;

   // One reading as it leaves the result channel.
   typedef struct packed {
      logic [RATE_W-1:0]      rate_bpm;
      logic                   beat_seen;
      logic                   in_beat;
      logic [SAMPLE_BITS-1:0] level;
   } rate_reading_t;

   // Run control. The watchdog limit covers the long receiver hold-off several times over,
   // since that is the longest stretch in which no beat moves on either channel.
   localparam int unsigned ITEM_TARGET = 1600;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned END_TAIL    = 64;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   pbrd_csr_type         csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   pulse_t               req_sample;
   stamp_t               req_now_ms;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [RATE_W-1:0]    rsp_rate_bpm;
   logic                 rsp_beat_seen;
   logic                 rsp_in_beat;
   pulse_t               rsp_level;

   pulse_beat_rate_detector i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rate_bpm  (rsp_rate_bpm),
      .rsp_beat_seen (rsp_beat_seen),
      .rsp_in_beat   (rsp_in_beat),
      .rsp_level     (rsp_level)
   );

   // Readings predicted for accepted samples, oldest first.
   rate_reading_t pending_readings[$];

   // Tracker settings as the block should hold them.
   logic [CSR_W-1:0]  set_window;
   logic [CSR_W-1:0]  set_min_ivl;
   logic [CSR_W-1:0]  set_max_ivl;
   logic [CSR_W-1:0]  set_timeout;
   logic [SPAN_W-1:0] set_min_span;
   logic [SPAN_W-1:0] set_hyst;
   logic [RATE_W-1:0] set_floor;
   logic [RATE_W-1:0] set_ceiling;

   // Tracker state: window extremes, threshold, heartbeat history and the rate.
   pulse_t            trk_low;
   pulse_t            trk_high;
   pulse_t            trk_level;
   stamp_t            trk_win_begin;
   stamp_t            trk_last_beat;
   logic [IVL_W-1:0]  trk_ring[RING_DEPTH];
   int unsigned       trk_slot;
   int unsigned       trk_fill;
   logic              trk_armed;
   logic [RATE_W-1:0] trk_rate;

   // Idling controls shared by the stimulus and the receiver.
   bit send_gaps_on;
   bit stall_gaps_on;
   bit hold_request;

   int unsigned mismatch_count;
   int unsigned samples_sent;
   int unsigned readings_checked;
   int unsigned heartbeats_seen;
   int unsigned rate_updates;
   int unsigned setting_writes;
   int unsigned quiet_cycles;

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Tracker model
   // -------------------------------------------------------------------------

   // Puts settings and state back to their values after reset.
   function automatic void clear_tracker();
      set_window   = WINDOW_RST;
      set_min_ivl  = MIN_IVL_RST;
      set_max_ivl  = MAX_IVL_RST;
      set_timeout  = TIMEOUT_RST;
      set_min_span = MIN_SPAN_RST;
      set_hyst     = HYST_RST;
      set_floor    = FLOOR_RST;
      set_ceiling  = CEIL_RST;
      trk_low       = SAMPLE_MAX;
      trk_high      = '0;
      trk_level     = LEVEL_RST;
      trk_win_begin = '0;
      trk_last_beat = '0;
      foreach (trk_ring[i]) trk_ring[i] = '0;
      trk_slot  = 0;
      trk_fill  = 0;
      trk_armed = 1'b0;
      trk_rate  = '0;
   endfunction

   // Advances the tracker by one sample and returns the reading it produces. All time
   // differences are 32-bit and wrap, exactly as the time stamps do.
   function automatic rate_reading_t track_pulse(pulse_t pulse, stamp_t stamp);
      rate_reading_t reading;
      int unsigned   span;
      int unsigned   ivl;
      int unsigned   total;
      int unsigned   mean;
      int unsigned   bpm;
      int unsigned   k;
      logic          started;
      started = 1'b0;

      // The window restarts once strictly more than window_ms has gone by.
      if (stamp_t'(stamp - trk_win_begin) > stamp_t'(set_window)) begin
         trk_low       = SAMPLE_MAX;
         trk_high      = '0;
         trk_win_begin = stamp;
      end
      if (pulse < trk_low)  trk_low  = pulse;
      if (pulse > trk_high) trk_high = pulse;
      if (32'(trk_high) > 32'(trk_low) + 32'(set_min_span)) begin
         span      = 32'(trk_high) - 32'(trk_low);
         trk_level = pulse_t'(32'(trk_low) + (span * 7) / 10);
      end

      // A rising crossing while not in a heartbeat starts one. A stamp of zero stands
      // for "no heartbeat yet", so a heartbeat at time zero has no predecessor.
      if (!trk_armed && pulse > trk_level) begin
         ivl = stamp - trk_last_beat;
         if (trk_last_beat != '0 && ivl >= 32'(set_min_ivl) && ivl <= 32'(set_max_ivl)) begin
            trk_ring[trk_slot] = IVL_W'(ivl);
            trk_slot = (trk_slot + 1) % RING_DEPTH;
            if (trk_fill < RING_DEPTH) trk_fill++;
            total = 0;
            for (k = 0; k < trk_fill; k++) total += 32'(trk_ring[k]);
            mean = total / trk_fill;
            // A zero mean gives a zero quotient, which the floor then lifts.
            bpm = (mean > 0) ? 32'd60000 / mean : 0;
            // Floor first and ceiling last, so the ceiling wins when they cross.
            if (bpm < 32'(set_floor))   bpm = 32'(set_floor);
            if (bpm > 32'(set_ceiling)) bpm = 32'(set_ceiling);
            trk_rate = RATE_W'(bpm);
            rate_updates++;
         end
         trk_last_beat = stamp;
         trk_armed     = 1'b1;
         started       = 1'b1;
      end

      // Re-arm only on a fall of more than hysteresis below the threshold; written as
      // a sum so a threshold below the hysteresis never re-arms.
      if (trk_armed && 32'(pulse) + 32'(set_hyst) < 32'(trk_level)) trk_armed = 1'b0;

      // Silence after the last heartbeat empties the history, on every sample it lasts.
      if (trk_last_beat != '0 && stamp_t'(stamp - trk_last_beat) > stamp_t'(set_timeout)) begin
         trk_rate = '0;
         trk_fill = 0;
         trk_slot = 0;
      end

      reading.rate_bpm  = trk_rate;
      reading.beat_seen = started;
      reading.in_beat   = trk_armed;
      reading.level     = trk_level;
      if (started) heartbeats_seen++;
      return reading;
   endfunction

   // -------------------------------------------------------------------------
   // Shared stimulus pieces
   // -------------------------------------------------------------------------

   // Idle stretch length: from the short range in 88 of 100 draws, else from the long one.
   function automatic int unsigned pick_idle_len();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one sample on the req channel and waits for its beat to be taken. Entered
   // and left on a falling edge; valid stays high on exit so that a following sample
   // without a gap keeps it high without a drop.
   task automatic send_pulse(pulse_t pulse, stamp_t stamp);
      int unsigned gap;
      gap = 0;
      if (send_gaps_on && $urandom_range(0, 99) >= 65) gap = pick_idle_len();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_sample = pulse;
      req_now_ms = stamp;
      req_valid  = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(track_pulse(pulse, stamp));
      samples_sent++;
      @(negedge clock);
   endtask

   // Drops valid and waits until every predicted reading has come back. Every sample
   // yields a reading, so the block is idle once the last one is taken.
   task automatic wait_until_drained();
      req_valid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes one register and mirrors the write into the model settings.
   task automatic write_setting(pbrd_csr_type idx, logic [CSR_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_WINDOW_MS:       set_window   = value;
         CSR_MIN_INTERVAL_MS: set_min_ivl  = value;
         CSR_MAX_INTERVAL_MS: set_max_ivl  = value;
         CSR_TIMEOUT_MS:      set_timeout  = value;
         CSR_MIN_SPAN:        set_min_span = value[SPAN_W-1:0];
         CSR_HYSTERESIS:      set_hyst     = value[SPAN_W-1:0];
         CSR_RATE_FLOOR:      set_floor    = value[RATE_W-1:0];
         CSR_RATE_CEILING:    set_ceiling  = value[RATE_W-1:0];
      endcase
      setting_writes++;
   endtask

   // Plays a synthetic pulse train: a baseline with a square peak once per period, a
   // little noise on top and a random start time anywhere in the 32-bit range. Some
   // samples, at the given percentage, are broken: a wild sample or a jump in time.
   task automatic play_rhythm(int unsigned count, int unsigned broken_pct);
      stamp_t      stamp;
      int unsigned step_ms;
      int unsigned period;
      int unsigned width;
      int unsigned base;
      int unsigned swing;
      int unsigned value;
      int unsigned k;
      stamp   = $urandom();
      step_ms = $urandom_range(2, 40);
      period  = $urandom_range(300, 1600) / step_ms + 1;
      width   = $urandom_range(1, (period + 1) / 2);
      base    = $urandom_range(0, 3500);
      swing   = $urandom_range(100, 4095 - base);
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < broken_pct) begin
            case ($urandom_range(0, 2))
               0: value = $urandom_range(0, 4095);
               1: begin
                  stamp += $urandom_range(0, 20000);
                  value = base;
               end
               default: begin
                  stamp -= $urandom_range(0, 3000);
                  value = base + swing;
               end
            endcase
         end else begin
            value = base + (((k % period) < width) ? swing : 0) + $urandom_range(0, swing / 8);
         end
         if (value > 4095) value = 4095;
         send_pulse(pulse_t'(value), stamp);
         stamp += step_ms + $urandom_range(0, step_ms / 4);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Hand-picked samples under the reset settings: full-scale swings, a heartbeat at
   // time zero, intervals inside and on both sides of the accepted range, a timeout
   // that persists, and time stamps that wrap past the top of the 32-bit range.
   task automatic test_directed_cases();
      pulse_t seq_pulse[22] = '{
         12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2000,
         12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0,
         12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095};
      stamp_t seq_stamp[22] = '{
         32'd0, 32'd100, 32'd400, 32'd500, 32'd1100, 32'd1400, 32'd1700, 32'd1800,
         32'd2000, 32'd2100, 32'd2300, 32'd2350, 32'd2500, 32'd5000, 32'd9500, 32'd9600,
         32'hFFFF_FE00, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_0200, 32'h0000_0280,
         32'h0000_0500};
      int unsigned k;
      for (k = 0; k < 22; k++) send_pulse(seq_pulse[k], seq_stamp[k]);
      wait_until_drained();
   endtask

   // Runs through the register extremes: zero intervals with the floor above the ceiling and
   // then below it until the mean interval is zero, a threshold that never moves with a
   // hysteresis no sample can clear, zero window and timeout, a one millisecond timeout,
   // and finally the reset values again.
   task automatic test_setting_extremes();
      stamp_t      same_ms;
      int unsigned k;
      same_ms = 32'h4000_0000;

      // Heartbeats stamped with the same time give zero intervals. The first one is
      // far from the last heartbeat, so its interval is out of range and not stored.
      write_setting(CSR_WINDOW_MS, 16'hFFFF);
      write_setting(CSR_MIN_INTERVAL_MS, 16'd0);
      write_setting(CSR_MAX_INTERVAL_MS, 16'hFFFF);
      write_setting(CSR_TIMEOUT_MS, 16'hFFFF);
      write_setting(CSR_MIN_SPAN, 16'd0);
      write_setting(CSR_HYSTERESIS, 16'd0);
      write_setting(CSR_RATE_FLOOR, 16'd255);
      write_setting(CSR_RATE_CEILING, 16'd0);
      for (k = 0; k < 6; k++) send_pulse((k % 2) ? 12'd0 : 12'd4095, same_ms);
      wait_until_drained();
      write_setting(CSR_RATE_FLOOR, 16'd40);
      write_setting(CSR_RATE_CEILING, 16'd255);
      for (k = 0; k < 13; k++) send_pulse((k % 2) ? 12'd0 : 12'd4095, same_ms);
      wait_until_drained();

      write_setting(CSR_WINDOW_MS, 16'd0);
      write_setting(CSR_MIN_INTERVAL_MS, 16'hFFFF);
      write_setting(CSR_MAX_INTERVAL_MS, 16'd0);
      write_setting(CSR_TIMEOUT_MS, 16'd0);
      write_setting(CSR_MIN_SPAN, 16'd4095);
      write_setting(CSR_HYSTERESIS, 16'd4095);
      play_rhythm(30, 10);
      wait_until_drained();

      write_setting(CSR_WINDOW_MS, 16'hFFFF);
      write_setting(CSR_MIN_INTERVAL_MS, 16'd0);
      write_setting(CSR_MAX_INTERVAL_MS, 16'hFFFF);
      write_setting(CSR_TIMEOUT_MS, 16'd1);
      write_setting(CSR_MIN_SPAN, 16'd0);
      write_setting(CSR_HYSTERESIS, 16'd0);
      write_setting(CSR_RATE_FLOOR, 16'd0);
      play_rhythm(40, 0);
      wait_until_drained();

      write_setting(CSR_WINDOW_MS, WINDOW_RST);
      write_setting(CSR_MIN_INTERVAL_MS, MIN_IVL_RST);
      write_setting(CSR_MAX_INTERVAL_MS, MAX_IVL_RST);
      write_setting(CSR_TIMEOUT_MS, TIMEOUT_RST);
      write_setting(CSR_MIN_SPAN, CSR_W'(MIN_SPAN_RST));
      write_setting(CSR_HYSTERESIS, CSR_W'(HYST_RST));
      write_setting(CSR_RATE_FLOOR, CSR_W'(FLOOR_RST));
      write_setting(CSR_RATE_CEILING, CSR_W'(CEIL_RST));
      play_rhythm(40, 5);
      wait_until_drained();
   endtask

   // The receiver holds off for a long stretch while samples keep coming back to back,
   // so the output register fills and the block has to stall its req side.
   task automatic test_output_backpressure();
      send_gaps_on = 1'b0;
      hold_request = 1'b1;
      play_rhythm(40, 0);
      wait_until_drained();
      send_gaps_on = 1'b1;
   endtask

   // Random pulse trains, each under freshly drawn settings. Mostly the settings are in a
   // plausible range for a heart rate monitor; now and then all are drawn over their full
   // width. Idling on either side is switched off for some trains.
   task automatic test_random_rhythm();
      bit wild;
      while (samples_sent < ITEM_TARGET) begin
         wait_until_drained();
         wild = ($urandom_range(0, 4) == 0);
         write_setting(CSR_WINDOW_MS,
            CSR_W'(wild ? $urandom_range(0, 65535) : $urandom_range(100, 3000)));
         write_setting(CSR_MIN_INTERVAL_MS,
            CSR_W'(wild ? $urandom_range(0, 65535) : $urandom_range(100, 600)));
         write_setting(CSR_MAX_INTERVAL_MS,
            CSR_W'(wild ? $urandom_range(0, 65535) : $urandom_range(1000, 3000)));
         write_setting(CSR_TIMEOUT_MS,
            CSR_W'(wild ? $urandom_range(0, 65535) : $urandom_range(2000, 8000)));
         write_setting(CSR_MIN_SPAN,
            CSR_W'(wild ? $urandom_range(0, 4095) : $urandom_range(0, 300)));
         write_setting(CSR_HYSTERESIS,
            CSR_W'(wild ? $urandom_range(0, 4095) : $urandom_range(0, 200)));
         write_setting(CSR_RATE_FLOOR,
            CSR_W'(wild ? $urandom_range(0, 255) : $urandom_range(20, 60)));
         write_setting(CSR_RATE_CEILING,
            CSR_W'(wild ? $urandom_range(0, 255) : $urandom_range(150, 255)));
         send_gaps_on  = ($urandom_range(0, 3) != 0);
         stall_gaps_on = ($urandom_range(0, 3) != 0);
         play_rhythm($urandom_range(60, 160), 10);
      end
      send_gaps_on  = 1'b1;
      stall_gaps_on = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stall stretches, plus the long hold-off on request. The
   // hold-off is counted here, in cycles, independent of the sender.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      int unsigned held;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall    = 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (stall_gaps_on && $urandom_range(0, 99) < 20) begin
            rsp_stall  = 1'b1;
            stall_left = pick_idle_len() - 1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result check: each rsp beat against the oldest predicted reading.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rate_reading_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("reading with none predicted: rate_bpm %0d beat_seen %0d in_beat %0d level %0d",
                   rsp_rate_bpm, rsp_beat_seen, rsp_in_beat, rsp_level);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (rsp_rate_bpm !== want.rate_bpm) begin
               $error("rate_bpm: expected %0d, actual %0d", want.rate_bpm, rsp_rate_bpm);
               mismatch_count++;
            end
            if (rsp_beat_seen !== want.beat_seen) begin
               $error("beat_seen: expected %0d, actual %0d", want.beat_seen, rsp_beat_seen);
               mismatch_count++;
            end
            if (rsp_in_beat !== want.in_beat) begin
               $error("in_beat: expected %0d, actual %0d", want.in_beat, rsp_in_beat);
               mismatch_count++;
            end
            if (rsp_level !== want.level) begin
               $error("level: expected %0d, actual %0d", want.level, rsp_level);
               mismatch_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run when no beat has moved on either channel for too long.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d readings outstanding.",
                     quiet_cycles, pending_readings.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_WINDOW_MS;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_sample    = '0;
      req_now_ms    = '0;
      send_gaps_on  = 1'b1;
      stall_gaps_on = 1'b1;
      hold_request  = 1'b0;
      mismatch_count   = 0;
      samples_sent     = 0;
      readings_checked = 0;
      heartbeats_seen  = 0;
      rate_updates     = 0;
      setting_writes   = 0;
      quiet_cycles     = 0;
      clear_tracker();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_setting_extremes();
      test_output_backpressure();
      test_random_rhythm();

      // Let any stray reading show up before the verdict.
      wait_until_drained();
      repeat (END_TAIL) @(posedge clock);

      $display("Sent %0d samples with %0d heartbeats and %0d rate updates, %0d register writes.",
               samples_sent, heartbeats_seen, rate_updates, setting_writes);
      $display("Checked %0d readings under random idling and one long receiver hold-off.",
               readings_checked);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> pulse_beat_rate_detector.f
+incdir+rtl
rtl/pbrd_pkg.sv
rtl/pbrd_div.sv
rtl/pbrd_dp.sv
rtl/pbrd_ctrl.sv
rtl/pulse_beat_rate_detector.sv
dv/tb_pulse_beat_rate_detector.sv
